### src/cone_direction_rotation_core_defines.svh
// ----------------------------------------------------------------------------
// Cone direction rotation core assertion macros
// Concurrent assertion helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CONE_DIRECTION_ROTATION_CORE_DEFINES_SVH
`define CONE_DIRECTION_ROTATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cone direction rotation check failed");
`define CDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cone direction rotation check failed");
`else
`define CDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/cdr_pkg.sv
// ----------------------------------------------------------------------------
// Cone direction rotation package
// Payload types, fixed-point formats, CORDIC constants and multiply helpers.
// ----------------------------------------------------------------------------
package cdr_pkg;

	localparam int QB = 30;
	localparam int QW = 34;
	localparam int VW = 36;
	localparam int ZW = 34;

	typedef logic signed [QW-1:0] q_t;
	typedef logic signed [VW-1:0] v_t;
	typedef logic signed [ZW-1:0] z_t;

	localparam logic signed [30:0] GAIN = 31'sd652032874;

	localparam z_t ATAN_TAB [0:30] = '{
		34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
		34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
		34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
		34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
		34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
		34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051,
		34'sh000000029, 34'sh000000014, 34'sh00000000A, 34'sh000000005,
		34'sh000000003, 34'sh000000001, 34'sh000000001
	};

	typedef struct packed {
		logic [15:0] axis_polar;
		logic [15:0] axis_azimuth;
		logic [15:0] cone_half_angle;
		logic [15:0] rotation_azimuth;
	} req_t;

	typedef struct packed {
		logic [15:0] out_polar;
		logic [15:0] out_azimuth;
		logic        degenerate;
	} res_t;

	// Pole-axis shortcut carried alongside the datapath.
	typedef struct packed {
		logic        pole;
		logic [15:0] pol;
		logic [15:0] az;
	} side_t;

	typedef struct packed {
		side_t sd;
		q_t    c1;
	} side1_t;

	typedef struct packed {
		side_t sd;
		z_t    za;
		v_t    rho;
	} side2_t;

	// Q4.30 product, rounded toward minus infinity.
	function automatic q_t qmul(input q_t a, input q_t b);
		logic signed [2*QW-1:0] p;
		p = a * b;
		return q_t'(p >>> QB);
	endfunction

	function automatic v_t gmul(input v_t x);
		logic signed [VW+30:0] p;
		p = x * GAIN;
		return v_t'(p >>> QB);
	endfunction

endpackage

### src/cdr_rot_cordic.sv
// ----------------------------------------------------------------------------
// Cone direction rotation: rotation-mode CORDIC
// Four lanes of pipelined sine and cosine, one CORDIC step per stage.
// ----------------------------------------------------------------------------
module cdr_rot_cordic import cdr_pkg::*; #(
	parameter int STEPS  = 18,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [31:0]       phase [4],
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [SIDE_W-1:0] out_side,
	output q_t                cos_v [4],
	output q_t                sin_v [4]
);

	q_t                x_s    [1:STEPS][4];
	q_t                y_s    [1:STEPS][4];
	z_t                z_s    [1:STEPS][4];
	logic              flip_s [1:STEPS][4];
	logic              vld_s  [1:STEPS];
	logic [SIDE_W-1:0] side_s [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              vld_k;
		logic [SIDE_W-1:0] side_k;
		q_t                x_k    [4];
		q_t                y_k    [4];
		z_t                z_k    [4];
		logic              flip_k [4];

		if (k == 0) begin : g_src
			// The angle is folded into the right half plane; the fold negates the result.
			always_comb begin
				logic [31:0] pf;
				vld_k  = in_valid;
				side_k = in_side;
				for (int l = 0; l < 4; l++) begin
					pf = phase[l];
					flip_k[l] = 1'b0;
					if ((phase[l] + 32'h4000_0000) >= 32'h8000_0000) begin
						pf = phase[l] + 32'h8000_0000;
						flip_k[l] = 1'b1;
					end
					x_k[l] = q_t'(GAIN);
					y_k[l] = '0;
					z_k[l] = z_t'(signed'(pf));
				end
			end
		end else begin : g_src
			always_comb begin
				vld_k  = vld_s[k];
				side_k = side_s[k];
				for (int l = 0; l < 4; l++) begin
					x_k[l]    = x_s[k][l];
					y_k[l]    = y_s[k][l];
					z_k[l]    = z_s[k][l];
					flip_k[l] = flip_s[k][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_k;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_k;
				for (int l = 0; l < 4; l++) begin
					flip_s[k+1][l] <= flip_k[l];
					if (z_k[l] >= 0) begin
						x_s[k+1][l] <= x_k[l] - (y_k[l] >>> k);
						y_s[k+1][l] <= y_k[l] + (x_k[l] >>> k);
						z_s[k+1][l] <= z_k[l] - ATAN_TAB[k];
					end else begin
						x_s[k+1][l] <= x_k[l] + (y_k[l] >>> k);
						y_s[k+1][l] <= y_k[l] - (x_k[l] >>> k);
						z_s[k+1][l] <= z_k[l] + ATAN_TAB[k];
					end
				end
			end
		end
	end

	always_comb begin
		out_valid = vld_s[STEPS];
		out_side  = side_s[STEPS];
		for (int l = 0; l < 4; l++) begin
			cos_v[l] = flip_s[STEPS][l] ? -x_s[STEPS][l] : x_s[STEPS][l];
			sin_v[l] = flip_s[STEPS][l] ? -y_s[STEPS][l] : y_s[STEPS][l];
		end
	end

endmodule

### src/cdr_vec_cordic.sv
// ----------------------------------------------------------------------------
// Cone direction rotation: vectoring-mode CORDIC
// Pipelined angle and scaled magnitude of a vector, one step per stage.
// ----------------------------------------------------------------------------
module cdr_vec_cordic import cdr_pkg::*; #(
	parameter int STEPS  = 18,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  v_t                in_x,
	input  v_t                in_y,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [SIDE_W-1:0] out_side,
	output v_t                out_x,
	output z_t                out_z
);

	v_t                x_s    [1:STEPS];
	v_t                y_s    [1:STEPS];
	z_t                z_s    [1:STEPS];
	logic              vld_s  [1:STEPS];
	logic [SIDE_W-1:0] side_s [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              vld_k;
		logic [SIDE_W-1:0] side_k;
		v_t                x_k;
		v_t                y_k;
		z_t                z_k;

		if (k == 0) begin : g_src
			// A vector in the left half plane is first turned by a quarter turn.
			always_comb begin
				vld_k  = in_valid;
				side_k = in_side;
				x_k    = in_x;
				y_k    = in_y;
				z_k    = '0;
				if (in_x < 0) begin
					if (in_y >= 0) begin
						x_k = in_y;
						y_k = -in_x;
						z_k = z_t'(34'sh040000000);
					end else begin
						x_k = -in_y;
						y_k = in_x;
						z_k = -z_t'(34'sh040000000);
					end
				end
			end
		end else begin : g_src
			always_comb begin
				vld_k  = vld_s[k];
				side_k = side_s[k];
				x_k    = x_s[k];
				y_k    = y_s[k];
				z_k    = z_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_k;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_k;
				if (y_k >= 0) begin
					x_s[k+1] <= x_k + (y_k >>> k);
					y_s[k+1] <= y_k - (x_k >>> k);
					z_s[k+1] <= z_k + ATAN_TAB[k];
				end else begin
					x_s[k+1] <= x_k - (y_k >>> k);
					y_s[k+1] <= y_k + (x_k >>> k);
					z_s[k+1] <= z_k - ATAN_TAB[k];
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_side  = side_s[STEPS];
	assign out_x     = x_s[STEPS];
	assign out_z     = z_s[STEPS];

endmodule

### src/cone_direction_rotation_core.sv
// ----------------------------------------------------------------------------
// Cone direction rotation core
// Rotates a cone axis direction by a half-angle and an azimuth and returns the
// resulting polar angle and azimuth in binary angle units.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                      Payload
//   request   req_valid, req_stall, req    axis polar/azimuth, half-angle, azimuth
//   result    res_valid, res_stall, res    polar, azimuth, degenerate flag
//
// One request enters per clock and one result leaves per clock while the
// pipeline is not held. A request passes through input capture, the sine/cosine
// CORDIC, three multiply/add stages, the azimuth CORDIC, the magnitude scaling,
// the polar CORDIC and the result register. Each CORDIC spends one stage per
// step. There is no internal state, so reset only clears the valid bits.
// When a result sits in the output register and res_stall is high, the whole
// pipeline holds and req_stall is raised; nothing is dropped or repeated.
//
`include "cone_direction_rotation_core_defines.svh"

module cone_direction_rotation_core import cdr_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int TRIG_STEPS = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int SH    = 32 - ANGLE_BITS;
	localparam v_t RHO_MIN = v_t'(64'd1 << SH);

	// The pipeline moves as a whole whenever the output register can take a result.
	logic adv;
	assign adv       = !(res_valid && res_stall);
	assign req_stall = !adv;

	// Phase to angle units, rounded half up and cut to the field width.
	function automatic logic [15:0] to_units(input logic [31:0] w);
		logic [31:0] r;
		r = (w + (32'd1 << (31 - ANGLE_BITS))) >> SH;
		return r[15:0];
	endfunction

	// ---------------- Stage 1: request capture and pole shortcuts ----------------
	logic [31:0] ph_in [4];
	side_t       side_in;

	always_comb begin
		ph_in[0] = {16'b0, req.axis_polar} << SH;
		ph_in[1] = {16'b0, req.axis_azimuth} << SH;
		ph_in[2] = {16'b0, req.cone_half_angle} << SH;
		ph_in[3] = {16'b0, req.rotation_azimuth} << SH;
		side_in.pole = (ph_in[0] == 32'h0) || (ph_in[0] == 32'h8000_0000);
		side_in.pol  = (ph_in[0] == 32'h0) ? 16'((ph_in[2] >> SH))
			: 16'(((32'h8000_0000 - ph_in[2]) >> SH));
		side_in.az   = 16'((ph_in[3] >> SH));
	end

	logic        vld_s1;
	logic [31:0] ph_s1 [4];
	side_t       side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s1   <= ph_in;
			side_s1 <= side_in;
		end
	end

	// ---------------- Sines and cosines of all four angles ----------------
	// Lane order: axis polar, axis azimuth, half-angle, rotation azimuth.
	logic                 rot_valid;
	logic [$bits(side_t)-1:0] rot_side;
	q_t                   cs [4];
	q_t                   sn [4];

	cdr_rot_cordic #(
		.STEPS  (TRIG_STEPS),
		.SIDE_W ($bits(side_t))
	) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1),
		.phase     (ph_s1),
		.in_side   (side_s1),
		.out_valid (rot_valid),
		.out_side  (rot_side),
		.cos_v     (cs),
		.sin_v     (sn)
	);

	// ---------------- Stage 2: first products ----------------
	logic  vld_s2;
	side_t side_s2;
	q_t    shcr_s2, shsr_s2, chcp_s2, spch_s2, cpca_s2, sacp_s2, sp_s2, ca_s2, sa_s2;

	// ---------------- Stage 3: second products ----------------
	logic  vld_s3;
	side_t side_s3;
	q_t    tc_s3, a1_s3, a2_s3, a3_s3, b1_s3, b2_s3, b3_s3, chcp_s3;

	// ---------------- Stage 4: direction cosines ----------------
	logic  vld_s4;
	side_t side_s4;
	q_t    c1_s4, u_s4, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= rot_valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_t'(rot_side);
			shcr_s2 <= qmul(sn[2], cs[3]);
			shsr_s2 <= qmul(sn[2], sn[3]);
			chcp_s2 <= qmul(cs[2], cs[0]);
			spch_s2 <= qmul(sn[0], cs[2]);
			cpca_s2 <= qmul(cs[0], cs[1]);
			sacp_s2 <= qmul(sn[1], cs[0]);
			sp_s2   <= sn[0];
			ca_s2   <= cs[1];
			sa_s2   <= sn[1];

			side_s3 <= side_s2;
			tc_s3   <= qmul(sp_s2, shcr_s2);
			a1_s3   <= qmul(cpca_s2, shcr_s2);
			a2_s3   <= qmul(sa_s2, shsr_s2);
			a3_s3   <= qmul(ca_s2, spch_s2);
			b1_s3   <= qmul(sacp_s2, shcr_s2);
			b2_s3   <= qmul(ca_s2, shsr_s2);
			b3_s3   <= qmul(sa_s2, spch_s2);
			chcp_s3 <= chcp_s2;

			side_s4 <= side_s3;
			c1_s4   <= chcp_s3 - tc_s3;
			u_s4    <= a1_s3 - a2_s3 + a3_s3;
			v_s4    <= b1_s3 + b2_s3 + b3_s3;
		end
	end

	// ---------------- Azimuth and sine of the result polar angle ----------------
	side1_t                    v1_side_in, v1_side;
	logic [$bits(side1_t)-1:0] v1_side_raw;
	logic                      v1_valid;
	v_t                        v1_x;
	z_t                        v1_z;

	assign v1_side_in.sd = side_s4;
	assign v1_side_in.c1 = c1_s4;
	assign v1_side       = side1_t'(v1_side_raw);

	cdr_vec_cordic #(
		.STEPS  (TRIG_STEPS),
		.SIDE_W ($bits(side1_t))
	) u_vec_az (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s4),
		.in_x      (v_t'(u_s4)),
		.in_y      (v_t'(v_s4)),
		.in_side   (v1_side_in),
		.out_valid (v1_valid),
		.out_side  (v1_side_raw),
		.out_x     (v1_x),
		.out_z     (v1_z)
	);

	// ---------------- Stage 5: magnitude scaling ----------------
	logic  vld_s5;
	side_t side_s5;
	v_t    rho_s5;
	z_t    za_s5;
	q_t    c1_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= v1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= v1_side.sd;
			rho_s5  <= gmul(v1_x);
			za_s5   <= v1_z;
			c1_s5   <= v1_side.c1;
		end
	end

	// ---------------- Result polar angle ----------------
	side2_t                    v2_side_in, v2_side;
	logic [$bits(side2_t)-1:0] v2_side_raw;
	logic                      v2_valid;
	v_t                        v2_x;
	z_t                        v2_z;

	assign v2_side_in.sd  = side_s5;
	assign v2_side_in.za  = za_s5;
	assign v2_side_in.rho = rho_s5;
	assign v2_side        = side2_t'(v2_side_raw);

	cdr_vec_cordic #(
		.STEPS  (TRIG_STEPS),
		.SIDE_W ($bits(side2_t))
	) u_vec_pol (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s5),
		.in_x      (v_t'(c1_s5)),
		.in_y      (rho_s5),
		.in_side   (v2_side_in),
		.out_valid (v2_valid),
		.out_side  (v2_side_raw),
		.out_x     (v2_x),
		.out_z     (v2_z)
	);

	// ---------------- Result assembly ----------------
	// The polar phase is clamped to [0, half turn]. A result whose sine is under
	// RHO_MIN sits on a pole: azimuth zero, flagged; the pole shortcut overrides both.
	res_t res_d;
	z_t   zp;

	always_comb begin
		zp = v2_z;
		if (v2_z < 0) begin
			zp = '0;
		end else if (v2_z > z_t'(34'sh080000000)) begin
			zp = z_t'(34'sh080000000);
		end
		res_d.out_polar   = to_units(zp[31:0]);
		res_d.degenerate  = (v2_side.rho < RHO_MIN);
		res_d.out_azimuth = res_d.degenerate ? 16'd0 : to_units(v2_side.za[31:0]);
		if (v2_side.sd.pole) begin
			res_d.out_polar   = v2_side.sd.pol;
			res_d.out_azimuth = v2_side.sd.az;
			res_d.degenerate  = 1'b0;
		end
	end

	logic res_valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------- Checks ----------------
	`CDR_ASSERT_IMP(a_deg_az_zero, clk, arst_n, res_valid && res.degenerate, res.out_azimuth == 16'd0)
	`CDR_ASSERT_NXT(a_hold_pipe, clk, arst_n, !adv, $stable(v2_valid) && $stable(vld_s5))
	`CDR_ASSERT_IMP(a_rise_src, clk, arst_n, $rose(res_valid), $past(v2_valid))
	`CDR_ASSERT_IMP(a_pole_nodeg, clk, arst_n, v2_valid && v2_side.sd.pole, !res_d.degenerate)

endmodule
